### rtl/gmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmm_pkg
// Shared types and constants for the gap-method merge block.
// ----------------------------------------------------------------------------
package gmm_pkg;

    localparam int VALUE_W    = 64;
    localparam int LEN_W      = 6;
    localparam int POS_W      = 5;
    localparam int CFG_ADDR_W = 1;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FIRST_LEN  = 1'b0,
        CFG_SECOND_LEN = 1'b1
    } t_cfg_idx;

endpackage

### rtl/gap_method_inplace_merge_top.sv
`timescale 1ns / 1ps
// Loading takes one cycle per word; the merge starts the cycle after the last word.
// Merge: each compare-swap takes the states S_MCMP and S_MWR, set by the single
// write port of the element memory (lower and upper word are written in turn).
// Emit: per word a memory read, then the output register, plus output stall.
// Synchronous active-low reset clears control state and both length registers.
// ----------------------------------------------------------------------------
// gap_method_inplace_merge_top
// Loads two sorted runs into one memory, merges them with the gap method by
// read-compare-write sweeps, then streams the merged words out in order.
// ----------------------------------------------------------------------------
module gap_method_inplace_merge_top #(
    parameter int MAX_TOTAL = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gmm_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [gmm_pkg::LEN_W-1:0]            i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  gmm_pkg::t_value                      i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output gmm_pkg::t_value                      o_value_res,
    output logic [gmm_pkg::POS_W-1:0]            o_position,
    output logic                                 o_in_second,
    output logic                                 o_last
);

    localparam int CNT_W  = $clog2(MAX_TOTAL + 1);
    localparam int ADDR_W = (MAX_TOTAL > 1) ? $clog2(MAX_TOTAL) : 1;
    localparam logic [6:0] MAX7 = 7'(MAX_TOTAL);

    typedef enum logic [2:0] {
        S_LOAD,
        S_MRD,
        S_MCMP,
        S_MWR,
        S_ERD,
        S_EWAIT
    } t_state;

    // configuration
    logic [gmm_pkg::LEN_W-1:0] r_first_len;
    logic [gmm_pkg::LEN_W-1:0] r_second_len;

    logic [6:0]       first7;
    logic [6:0]       room7;
    logic [6:0]       second7;
    logic [6:0]       total7;
    logic [CNT_W-1:0] total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_len  <= '0;
            r_second_len <= '0;
        end else if (i_cfg_we) begin
            case (gmm_pkg::t_cfg_idx'(i_cfg_addr))
                gmm_pkg::CFG_FIRST_LEN:  r_first_len  <= i_cfg_wdata;
                gmm_pkg::CFG_SECOND_LEN: r_second_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        first7  = ({1'b0, r_first_len} > MAX7) ? MAX7 : {1'b0, r_first_len};
        room7   = MAX7 - first7;
        second7 = ({1'b0, r_second_len} > room7) ? room7 : {1'b0, r_second_len};
        total7  = first7 + second7;
        total   = total7[CNT_W-1:0];
    end

    // sequencer
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_load_cnt, n_load_cnt;
    logic [CNT_W-1:0]       r_gap, n_gap;
    logic [CNT_W-1:0]       r_pos, n_pos;
    gmm_pkg::t_value        r_hi_data, n_hi_data;
    logic                   r_out_valid, n_out_valid;
    gmm_pkg::t_value        r_out_value, n_out_value;
    logic [gmm_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic                   r_out_second, n_out_second;
    logic                   r_out_last, n_out_last;

    logic                   in_acc;
    logic                   out_acc;
    logic [CNT_W:0]         pair_hi;
    logic [CNT_W-1:0]       pos_inc;
    logic [CNT_W:0]         next_hi;
    logic [6:0]             pos7;
    logic                   pos_last;
    logic                   swap;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    gmm_pkg::t_value        mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr_a;
    logic [ADDR_W-1:0]      mem_raddr_b;
    gmm_pkg::t_value        mem_rdata_a;
    gmm_pkg::t_value        mem_rdata_b;

    assign o_stall = (r_state != S_LOAD);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;

    always_comb begin
        pair_hi  = {1'b0, r_pos} + {1'b0, r_gap};
        pos_inc  = r_pos + 1'b1;
        next_hi  = {1'b0, pos_inc} + {1'b0, r_gap};
        pos7     = 7'(r_pos);
        pos_last = ((pos7 + 7'd1) == total7);
        swap     = mem_rdata_a > mem_rdata_b;
    end

    always_comb begin
        n_state      = r_state;
        n_load_cnt   = r_load_cnt;
        n_gap        = r_gap;
        n_pos        = r_pos;
        n_hi_data    = r_hi_data;
        n_out_valid  = out_acc ? 1'b0 : r_out_valid;
        n_out_value  = r_out_value;
        n_out_pos    = r_out_pos;
        n_out_second = r_out_second;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = r_load_cnt[ADDR_W-1:0];
        mem_wdata    = i_value;
        mem_raddr_a  = r_pos[ADDR_W-1:0];
        mem_raddr_b  = pair_hi[ADDR_W-1:0];

        case (r_state)
            S_LOAD: begin
                if (i_cfg_we) begin
                    n_load_cnt = '0;
                end else if (in_acc && (total != '0)) begin
                    mem_we = 1'b1;
                    if ((r_load_cnt + 1'b1) == total) begin
                        n_load_cnt = '0;
                        n_gap      = (total >> 1) + CNT_W'(total[0]);
                        n_pos      = '0;
                        n_state    = S_MRD;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            S_MRD: begin
                // start a pair, or close the pass
                if (pair_hi < {1'b0, total}) begin
                    n_state = S_MCMP;
                end else if (r_gap == CNT_W'(1)) begin
                    n_pos   = '0;
                    n_state = S_ERD;
                end else begin
                    n_gap = (r_gap >> 1) + CNT_W'(r_gap[0]);
                    n_pos = '0;
                end
            end
            S_MCMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[ADDR_W-1:0];
                mem_wdata = swap ? mem_rdata_b : mem_rdata_a;
                n_hi_data = swap ? mem_rdata_a : mem_rdata_b;
                n_state   = S_MWR;
            end
            S_MWR: begin
                // write upper word; overlap the read of the next pair
                mem_we      = 1'b1;
                mem_waddr   = pair_hi[ADDR_W-1:0];
                mem_wdata   = r_hi_data;
                mem_raddr_a = pos_inc[ADDR_W-1:0];
                mem_raddr_b = next_hi[ADDR_W-1:0];
                n_pos       = pos_inc;
                n_state     = (next_hi < {1'b0, total}) ? S_MCMP : S_MRD;
            end
            S_ERD: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_EWAIT;
                end
            end
            S_EWAIT: begin
                n_out_valid  = 1'b1;
                n_out_value  = mem_rdata_a;
                n_out_pos    = pos7[gmm_pkg::POS_W-1:0];
                n_out_second = (pos7 >= first7);
                n_out_last   = pos_last;
                if (pos_last) begin
                    n_pos   = '0;
                    n_gap   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_pos   = pos_inc;
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= '0;
            r_gap       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_gap       <= n_gap;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_hi_data    <= n_hi_data;
        r_out_value  <= n_out_value;
        r_out_pos    <= n_out_pos;
        r_out_second <= n_out_second;
        r_out_last   <= n_out_last;
    end

    gmm_mem #(
        .DEPTH  (MAX_TOTAL),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    assign o_valid     = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_position  = r_out_pos;
    assign o_in_second = r_out_second;
    assign o_last      = r_out_last;

`ifndef ASSERT_OFF
    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRD || r_state == S_MCMP || r_state == S_MWR) |-> (r_gap != '0))
        else $error("merge running with zero gap");

    a_cmp_writes_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MCMP) |-> (mem_we && (mem_waddr == r_pos[ADDR_W-1:0])))
        else $error("compare cycle does not write lower word");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_position == gmm_pkg::POS_W'(total7 - 7'd1)))
        else $error("last word at wrong position");

    a_emit_loads_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWAIT) |-> (!r_out_valid || !i_stall))
        else $error("output register overwritten while stalled");

    a_last_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWAIT && pos_last) |=> (r_state == S_LOAD && o_valid && o_last))
        else $error("batch did not close after last word");
`endif

endmodule

### rtl/gmm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmm_mem
// Element store: one write port, two registered read ports. A read of the
// entry written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module gmm_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  gmm_pkg::t_value       i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr_a,
    input  logic [ADDR_W-1:0]     i_raddr_b,
    output gmm_pkg::t_value       o_rdata_a,
    output gmm_pkg::t_value       o_rdata_b
);

    gmm_pkg::t_value r_mem [DEPTH];
    gmm_pkg::t_value r_rdata_a;
    gmm_pkg::t_value r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
        r_rdata_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
